[rtl/lbtd_pkg.sv]
// Shared types, constants and the microcode program of the low-band transient detector.
package lbtd_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DECAY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DECAY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOKBACK   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY = 3'd5;

  localparam logic [23:0] RST_ATTACK     = 24'd16603361;
  localparam logic [23:0] RST_RELEASE    = 24'd16770227;
  localparam logic [23:0] RST_HOLD_DECAY = 24'd16774886;
  localparam logic [23:0] RST_MAX_DECAY  = 24'd16777199;
  localparam logic [10:0] RST_LOOKBACK   = 11'd1440;
  localparam logic [15:0] RST_REFRACTORY = 16'd5280;

  // The thresholds 0.12, 1.7 and 0.034 as exact ratios for cross-multiplication.
  localparam logic [28:0] FLOOR_ENV_K = 29'd25;
  localparam logic [28:0] FLOOR_MAX_K = 29'd3;
  localparam logic [32:0] RISE_ENV_K  = 33'd500;
  localparam logic [34:0] RISE_REF_K  = 35'd17;
  localparam logic [29:0] REF_HELD_K  = 30'd50;

  localparam logic [47:0] ROUND_HALF = 48'h00_0000_80_0000;
  localparam logic [3:0]  DIV_LAST   = 4'd15;

  typedef logic [3:0] step_t;

  localparam step_t ST_IDLE     = 4'd0;
  localparam step_t ST_LBRED    = 4'd1;
  localparam step_t ST_ADDR     = 4'd2;
  localparam step_t ST_MUL_ENV  = 4'd3;
  localparam step_t ST_ENV      = 4'd4;
  localparam step_t ST_MUL_HOLD = 4'd5;
  localparam step_t ST_HOLD     = 4'd6;
  localparam step_t ST_MUL_MAX  = 4'd7;
  localparam step_t ST_MAX      = 4'd8;
  localparam step_t ST_REF      = 4'd9;
  localparam step_t ST_DECIDE   = 4'd10;
  localparam step_t ST_DIV      = 4'd11;
  localparam step_t ST_OUT      = 4'd12;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_LBRED,
    OP_ADDR,
    OP_MUL_ENV,
    OP_ENV,
    OP_MUL_HOLD,
    OP_HOLD,
    OP_MUL_MAX,
    OP_MAX,
    OP_REF,
    OP_DECIDE,
    OP_DIV,
    OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_WAIT_IN,
    C_LOOP_LB,
    C_LOOP_DIV,
    C_SKIP_DIV,
    C_WAIT_FREE,
    C_GOTO
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode_rom(input step_t s);
    ctrl_word_t w;
    case (s)
      ST_IDLE:     w = '{OP_LOAD,     C_WAIT_IN,   ST_IDLE};
      ST_LBRED:    w = '{OP_LBRED,    C_LOOP_LB,   ST_IDLE};
      ST_ADDR:     w = '{OP_ADDR,     C_NEXT,      ST_IDLE};
      ST_MUL_ENV:  w = '{OP_MUL_ENV,  C_NEXT,      ST_IDLE};
      ST_ENV:      w = '{OP_ENV,      C_NEXT,      ST_IDLE};
      ST_MUL_HOLD: w = '{OP_MUL_HOLD, C_NEXT,      ST_IDLE};
      ST_HOLD:     w = '{OP_HOLD,     C_NEXT,      ST_IDLE};
      ST_MUL_MAX:  w = '{OP_MUL_MAX,  C_NEXT,      ST_IDLE};
      ST_MAX:      w = '{OP_MAX,      C_NEXT,      ST_IDLE};
      ST_REF:      w = '{OP_REF,      C_NEXT,      ST_IDLE};
      ST_DECIDE:   w = '{OP_DECIDE,   C_SKIP_DIV,  ST_OUT};
      ST_DIV:      w = '{OP_DIV,      C_LOOP_DIV,  ST_IDLE};
      ST_OUT:      w = '{OP_OUT,      C_WAIT_FREE, ST_IDLE};
      default:     w = '{OP_NOP,      C_GOTO,      ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

[rtl/low_band_transient_detector.sv]
// Top level of the low-band transient detector: microcode sequencer and datapath.
//
// One band-filtered 16-bit sample enters per input beat on the in_ channel and
// exactly one result beat leaves on the out_ channel: hit flag, strength
// (envelope over running maximum, Q0.16) and the updated envelope (Q16.8).
// A program of thirteen control words in a ROM steps a datapath with one
// 24x24 multiplier, a restoring divider and the peak-hold delay line RAM.
// An item passes through the lookback reduction and the envelope, hold and
// maximum updates to the decision, and through the divider only on a hit
// whose envelope is below the running maximum. The next sample can be
// accepted in the cycle after the result is loaded, so the block takes no
// new sample until the result of the last one has been loaded.
// After reset the delay line is cleared one entry per cycle; in_tready
// stays low meanwhile, while configuration writes are taken at once.
// The user must write configuration only while idle; the block does not enforce it.
// A result waits in the output register while out_tready is low; the next
// sample is still accepted and processed, and its result is held back at
// the last program step until the output register is free.
module low_band_transient_detector #(
  parameter int HISTORY_DEPTH = 2048
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // band_sample[15:0]
  input  logic [15:0]                     in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // hit[0], strength[16:1], envelope[40:17], zero[47:41]
  output logic [47:0]                     out_tdata,
  input  logic                            cfg_we,
  input  logic [lbtd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lbtd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lbtd_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam logic [16:0]   DEPTH_X = 17'(HISTORY_DEPTH);
  localparam logic [AW:0]   DEPTH_A = (AW+1)'(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(HISTORY_DEPTH - 1);

  logic [23:0] attack_r, release_r, hold_decay_r, max_decay_r;
  logic [10:0] lookback_r;
  logic [15:0] refractory_r;

  logic [23:0] env_r, held_r, max_r;
  logic [16:0] since_r;
  logic [AW-1:0] wp_r, clr_r;
  logic clearing_r;

  step_t step_r, step_nxt;
  ctrl_word_t ctrl;

  logic [23:0] mag_r, diff_r, rem_r;
  logic        rise_r, cmp_lo_r, hit_r;
  logic [10:0] lb_r;
  logic [47:0] prod_r;
  logic [29:0] ref_r;
  logic [15:0] quo_r, strength_r;
  logic [3:0]  div_cnt_r;
  logic        out_tvalid_r;
  logic [47:0] out_tdata_r;

  logic in_acc, lb_big, div_more, out_busy, hit_now, skip_div, hold, jump;
  logic [15:0] raw_mag;
  logic [23:0] mul_a, mul_b, env_step, prod_hi;
  logic [AW:0] lb_ext, rd_diff;
  logic [AW-1:0] rd_addr;
  logic [23:0] ram_rdata;
  logic ram_we;
  logic [AW-1:0] ram_waddr;
  logic [23:0] ram_wdata;
  logic [24:0] rem2;
  logic div_ge;
  logic [15:0] quo_new;

  assign ctrl      = ucode_rom(step_r);
  assign in_tready = (step_r == ST_IDLE) && !clearing_r;
  assign in_acc    = in_tvalid && in_tready;
  assign lb_big    = 17'(lb_r) >= DEPTH_X;
  assign div_more  = div_cnt_r != DIV_LAST;
  assign out_busy  = out_tvalid_r && !out_tready;

  assign raw_mag = in_tdata[15] ? 16'(-in_tdata) : in_tdata;

  assign hit_now = (since_r > {1'b0, refractory_r}) && cmp_lo_r &&
                   (35'(33'(env_r) * RISE_ENV_K) > 35'(ref_r) * RISE_REF_K);
  assign skip_div = !hit_now || (env_r >= max_r);

  always_comb begin
    hold = 1'b0;
    jump = 1'b0;
    case (ctrl.cond)
      C_NEXT:      ;
      C_WAIT_IN:   hold = !in_acc;
      C_LOOP_LB:   hold = lb_big;
      C_LOOP_DIV:  hold = div_more;
      C_SKIP_DIV:  jump = skip_div;
      C_WAIT_FREE: begin
        hold = out_busy;
        jump = !out_busy;
      end
      C_GOTO:      jump = 1'b1;
      default:     ;
    endcase
    if (jump) begin
      step_nxt = ctrl.target;
    end else if (hold) begin
      step_nxt = step_r;
    end else begin
      step_nxt = step_r + 4'd1;
    end
  end

  always_comb begin
    case (ctrl.op)
      OP_MUL_ENV: begin
        mul_a = diff_r;
        mul_b = rise_r ? attack_r : release_r;
      end
      OP_MUL_HOLD: begin
        mul_a = held_r;
        mul_b = hold_decay_r;
      end
      default: begin
        mul_a = max_r;
        mul_b = max_decay_r;
      end
    endcase
  end

  assign env_step = 24'((prod_r + ROUND_HALF) >> 24);
  assign prod_hi  = prod_r[47:24];

  assign lb_ext  = (AW+1)'(lb_r);
  assign rd_diff = {1'b0, wp_r} - lb_ext;
  assign rd_addr = ({1'b0, wp_r} >= lb_ext) ? rd_diff[AW-1:0] : AW'(rd_diff + DEPTH_A);

  assign rem2    = {rem_r, 1'b0};
  assign div_ge  = rem2 >= {1'b0, max_r};
  assign quo_new = {quo_r[14:0], div_ge};

  assign ram_we    = clearing_r || (ctrl.op == OP_MUL_MAX);
  assign ram_waddr = clearing_r ? clr_r : wp_r;
  assign ram_wdata = clearing_r ? 24'd0 : held_r;

  lbtd_ram #(
    .WIDTH (24),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ctrl.op == OP_ADDR),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r     <= RST_ATTACK;
      release_r    <= RST_RELEASE;
      hold_decay_r <= RST_HOLD_DECAY;
      max_decay_r  <= RST_MAX_DECAY;
      lookback_r   <= RST_LOOKBACK;
      refractory_r <= RST_REFRACTORY;
      env_r        <= '0;
      held_r       <= '0;
      max_r        <= '0;
      since_r      <= '0;
      wp_r         <= '0;
      clr_r        <= '0;
      clearing_r   <= 1'b1;
      step_r       <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (clearing_r) begin
        clr_r <= clr_r + 1'b1;
        if (clr_r == LAST_A) begin
          clearing_r <= 1'b0;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ATTACK:     attack_r     <= cfg_wdata;
          CFG_RELEASE:    release_r    <= cfg_wdata;
          CFG_HOLD_DECAY: hold_decay_r <= cfg_wdata;
          CFG_MAX_DECAY:  max_decay_r  <= cfg_wdata;
          CFG_LOOKBACK:   lookback_r   <= cfg_wdata[10:0];
          CFG_REFRACTORY: refractory_r <= cfg_wdata[15:0];
          default:        ;
        endcase
      end
      case (ctrl.op)
        OP_ENV:     env_r <= rise_r ? mag_r - env_step : mag_r + env_step;
        OP_HOLD:    held_r <= (env_r > prod_hi) ? env_r : prod_hi;
        OP_MUL_MAX: wp_r <= (wp_r == LAST_A) ? '0 : wp_r + 1'b1;
        OP_MAX: begin
          max_r <= (env_r > prod_hi) ? env_r : prod_hi;
          if (since_r != '1) begin
            since_r <= since_r + 17'd1;
          end
        end
        OP_DECIDE: begin
          if (hit_now) begin
            since_r <= '0;
          end
        end
        default: ;
      endcase
      if (ctrl.op == OP_OUT && !out_busy) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        if (in_acc) begin
          mag_r <= {raw_mag, 8'h00};
          lb_r  <= lookback_r;
        end
      end
      OP_LBRED: begin
        if (lb_big) begin
          lb_r <= 11'(17'(lb_r) - DEPTH_X);
        end
      end
      OP_ADDR: begin
        rise_r <= mag_r > env_r;
        diff_r <= (mag_r > env_r) ? mag_r - env_r : env_r - mag_r;
      end
      OP_MUL_ENV, OP_MUL_HOLD, OP_MUL_MAX: prod_r <= 48'(mul_a) * 48'(mul_b);
      OP_REF: begin
        ref_r    <= (30'(ram_rdata) * REF_HELD_K > 30'(max_r)) ?
                    30'(ram_rdata) * REF_HELD_K : 30'(max_r);
        cmp_lo_r <= 29'(env_r) * FLOOR_ENV_K > 29'(max_r) * FLOOR_MAX_K;
      end
      OP_DECIDE: begin
        hit_r      <= hit_now;
        strength_r <= (hit_now && env_r >= max_r) ? 16'hFFFF : 16'h0000;
        rem_r      <= env_r;
        quo_r      <= '0;
        div_cnt_r  <= '0;
      end
      OP_DIV: begin
        rem_r     <= div_ge ? 24'(rem2 - {1'b0, max_r}) : rem2[23:0];
        quo_r     <= quo_new;
        div_cnt_r <= div_cnt_r + 4'd1;
        if (!div_more) begin
          strength_r <= quo_new;
        end
      end
      OP_OUT: begin
        if (!out_busy) begin
          out_tdata_r <= {7'b0, env_r, strength_r, hit_r};
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_no_input_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_tready)
    else $error("Input accepted while the delay line is being cleared.");

  a_max_covers_env: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_DECIDE) |-> (max_r >= env_r))
    else $error("Running maximum fell below the envelope.");

  a_hit_restarts_refractory: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_DECIDE && hit_now) |=> (since_r == '0))
    else $error("Refractory count not restarted after a hit.");

  a_quiet_strength: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[16:1] == 16'd0))
    else $error("Nonzero strength on a beat without a hit.");

  a_wp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= LAST_A)
    else $error("Write pointer left the delay line.");

endmodule

[rtl/lbtd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lbtd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[tb/lbtd_checker.sv]
// Checker for the low-band transient detector: tracks its state, predicts each result beat and compares.
module lbtd_checker
  import lbtd_pkg::*;
#(
  parameter int HISTORY_DEPTH = 2048
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  // band_sample[15:0]
  input  logic [15:0]           in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // hit[0], strength[16:1], envelope[40:17], zero[47:41]
  input  logic [47:0]           out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output int                    beats_checked,
  output int                    hits_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit [16:0] SINCE_SAT = '1;
  localparam int MAX_PRINTED = 100;

  typedef struct packed {
    bit        hit;
    bit [15:0] strength;
    bit [23:0] envelope;
  } detection_t;

  bit [23:0] attack_k, release_k, hold_k, max_k;
  bit [10:0] lookback_len;
  bit [15:0] refractory_len;

  bit [23:0] fast_env, held_peak, running_max;
  bit [16:0] since_hit;
  bit [23:0] hold_line [HISTORY_DEPTH];
  int        wr_ptr;

  detection_t detections_due[$];
  int errors, checked, hits;

  function automatic bit [23:0] q24_scale(input bit [23:0] v, input bit [23:0] k,
                                          input bit round_up);
    bit [47:0] p;
    p = 48'(v) * 48'(k);
    if (round_up) begin
      p += 48'd1 << 23;
    end
    return p[47:24];
  endfunction

  function automatic detection_t detect_onset(input bit [15:0] sample);
    detection_t d;
    bit [16:0]  mag_raw;
    bit [23:0]  mag, earlier, decayed;
    bit [63:0]  env, mx, ref_lvl, ratio;
    int         rd;
    mag_raw = sample[15] ? 17'h10000 - {1'b0, sample} : {1'b0, sample};
    mag = {mag_raw[15:0], 8'h00};
    if (mag > fast_env) begin
      fast_env = mag - q24_scale(mag - fast_env, attack_k, 1'b1);
    end else begin
      fast_env = mag + q24_scale(fast_env - mag, release_k, 1'b1);
    end
    decayed = q24_scale(held_peak, hold_k, 1'b0);
    held_peak = (fast_env > decayed) ? fast_env : decayed;
    rd = (wr_ptr + HISTORY_DEPTH - int'(lookback_len) % HISTORY_DEPTH) % HISTORY_DEPTH;
    earlier = hold_line[rd];
    hold_line[wr_ptr] = held_peak;
    wr_ptr = (wr_ptr + 1) % HISTORY_DEPTH;
    decayed = q24_scale(running_max, max_k, 1'b0);
    running_max = (fast_env > decayed) ? fast_env : decayed;
    if (since_hit != SINCE_SAT) begin
      since_hit++;
    end
    env = 64'(fast_env);
    mx = 64'(running_max);
    ref_lvl = 64'(earlier) * 50;
    if (mx > ref_lvl) begin
      ref_lvl = mx;
    end
    d = '0;
    d.envelope = fast_env;
    if (since_hit > {1'b0, refractory_len} && env * 25 > mx * 3 &&
        env * 500 > ref_lvl * 17) begin
      d.hit = 1'b1;
      since_hit = '0;
      if (mx == 0) begin
        d.strength = '0;
      end else if (env >= mx) begin
        d.strength = 16'hFFFF;
      end else begin
        ratio = (env << 16) / mx;
        d.strength = (ratio > 64'd65535) ? 16'hFFFF : ratio[15:0];
      end
    end
    return d;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    // Printing stops after a while so a badly broken build cannot flood the log.
    if (errors < MAX_PRINTED) begin
      $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
    errors++;
  endtask

  always @(posedge clk) begin
    detection_t want;
    if (!rst_n) begin
      attack_k = RST_ATTACK;
      release_k = RST_RELEASE;
      hold_k = RST_HOLD_DECAY;
      max_k = RST_MAX_DECAY;
      lookback_len = RST_LOOKBACK;
      refractory_len = RST_REFRACTORY;
      fast_env = '0;
      held_peak = '0;
      running_max = '0;
      since_hit = '0;
      wr_ptr = 0;
      foreach (hold_line[i]) begin
        hold_line[i] = '0;
      end
      detections_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ATTACK:     attack_k = cfg_wdata;
          CFG_RELEASE:    release_k = cfg_wdata;
          CFG_HOLD_DECAY: hold_k = cfg_wdata;
          CFG_MAX_DECAY:  max_k = cfg_wdata;
          CFG_LOOKBACK:   lookback_len = cfg_wdata[10:0];
          CFG_REFRACTORY: refractory_len = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        checked++;
        if (detections_due.size() == 0) begin
          report_mismatch("result beat with nothing due", 0, out_tdata);
        end else begin
          want = detections_due.pop_front();
          if (want.hit) begin
            hits++;
          end
          if (out_tdata[0] !== want.hit) begin
            report_mismatch("hit", want.hit, out_tdata[0]);
          end
          if (out_tdata[16:1] !== want.strength) begin
            report_mismatch("strength", want.strength, out_tdata[16:1]);
          end
          if (out_tdata[40:17] !== want.envelope) begin
            report_mismatch("envelope", want.envelope, out_tdata[40:17]);
          end
          if (out_tdata[47:41] !== 7'd0) begin
            report_mismatch("padding bits", 0, out_tdata[47:41]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        detections_due.push_back(detect_onset(in_tdata));
      end
    end
    fail_count <= errors;
    pending <= detections_due.size();
    beats_checked <= checked;
    hits_seen <= hits;
  end

endmodule

[tb/tb_top.sv]
// Testbench top of the low-band transient detector: clock, reset, stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lbtd_pkg::*;

  localparam int HIST_DEPTH = 2048;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_SAMPLES = 190;
  localparam int PRESSURE_PHASE = 3;
  localparam int LONG_STALL = 400;
  localparam int TAIL_CYCLES = 64;

  typedef struct {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // band_sample[15:0]
  logic [15:0]           in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  // hit[0], strength[16:1], envelope[40:17], zero[47:41]
  logic [47:0]           out_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fail_count, pending, beats_checked, hits_seen;
  int settings_used = 1;
  bit idle_on = 1'b1;
  bit stall_request = 1'b0;
  reg_write_t reg_writes[$];

  logic [15:0] default_probe [10] = '{
    16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001,
    16'h5555, 16'hAAAA, 16'h8001, 16'h0000, 16'h7FFF
  };
  logic [15:0] onset_probe [12] = '{
    16'h0000, 16'h0001, 16'h7FFF, 16'd5000, 16'd3000, 16'h8000,
    16'h0000, 16'h4000, 16'hFFFF, 16'h4000, 16'h0100, 16'h7FFF
  };

  always #5 clk = ~clk;

  low_band_transient_detector #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  lbtd_checker #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .beats_checked (beats_checked),
    .hits_seen     (hits_seen)
  );

  task automatic send_sample(input logic [15:0] sample);
    if (idle_on && $urandom_range(4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= sample;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  task automatic queue_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
    reg_write_t w;
    w.idx = idx;
    w.data = data;
    reg_writes.push_back(w);
  endtask

  task automatic write_regs();
    foreach (reg_writes[i]) begin
      cfg_we <= 1'b1;
      cfg_index <= reg_writes[i].idx;
      cfg_wdata <= reg_writes[i].data;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    reg_writes.delete();
    settings_used++;
  endtask

  function automatic logic [23:0] pick_coef();
    case ($urandom_range(4))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      2:       return 24'($urandom);
      default: return 24'hFF0000 | 24'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic logic [10:0] pick_lookback();
    case ($urandom_range(4))
      0:       return 11'd0;
      1:       return 11'd1;
      2:       return 11'd2047;
      3:       return 11'($urandom_range(64, 2));
      default: return 11'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_refractory();
    case ($urandom_range(3))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(40, 1));
      default: return 16'($urandom);
    endcase
  endfunction

  // Quiet, moderate and loud stretches alternate so that onsets come often;
  // some stretches are plain noise over the full sample range.
  task automatic send_burst_sequence(input int count);
    int level, seg_len, n, k, v;
    n = 0;
    while (n < count) begin
      seg_len = $urandom_range(30, 1);
      case ($urandom_range(9))
        0, 1, 2: level = $urandom_range(64);
        3, 4:    level = $urandom_range(2000);
        5, 6, 7: level = $urandom_range(32767, 4000);
        default: level = -1;
      endcase
      for (k = 0; k < seg_len && n < count; k++) begin
        if (level < 0) begin
          v = int'($urandom_range(16'hFFFF));
        end else begin
          v = int'($urandom_range(2 * level)) - level;
        end
        send_sample(16'(v));
        n++;
      end
    end
  endtask

  initial begin
    out_tready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (stall_request) begin
        out_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        stall_request = 1'b0;
      end else if (idle_on && $urandom_range(3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(8, 1)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(8, 1)) @(posedge clk);
      end
    end
  end

  initial begin
    #4ms;
    $display("low_band_transient_detector verification failed");
    $finish;
  end

  initial begin
    logic [10:0] lb;
    logic [15:0] rf;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (default_probe[i]) begin
      send_sample(default_probe[i]);
    end
    wait_idle();

    // Instant attack and release, no peak hold, lookback of zero and no
    // refractory time: onsets and fractional strengths show up at once.
    queue_write(CFG_ATTACK, 24'h000000);
    queue_write(CFG_RELEASE, 24'h000000);
    queue_write(CFG_HOLD_DECAY, 24'h000000);
    queue_write(CFG_MAX_DECAY, 24'hFFFFFF);
    queue_write(CFG_LOOKBACK, 24'h000000);
    queue_write(CFG_REFRACTORY, 24'h000000);
    queue_write(CFG_SPARE_LO, 24'hFFFFFF);
    queue_write(CFG_SPARE_HI, 24'h5A5A5A);
    write_regs();
    foreach (onset_probe[i]) begin
      send_sample(onset_probe[i]);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      if (p == 0) begin
        queue_write(CFG_ATTACK, 24'hFFFFFF);
        queue_write(CFG_RELEASE, 24'hFFFFFF);
        queue_write(CFG_HOLD_DECAY, 24'hFFFFFF);
        queue_write(CFG_MAX_DECAY, 24'h000000);
        queue_write(CFG_LOOKBACK, 24'hFFF800 | 24'd2047);
        queue_write(CFG_REFRACTORY, 24'hAB0000 | 24'hFFFF);
      end else begin
        lb = (p == 1) ? 11'd1 : pick_lookback();
        rf = (p == 1) ? 16'd0 : pick_refractory();
        queue_write(CFG_ATTACK, pick_coef());
        queue_write(CFG_RELEASE, pick_coef());
        queue_write(CFG_HOLD_DECAY, pick_coef());
        queue_write(CFG_MAX_DECAY, pick_coef());
        queue_write(CFG_LOOKBACK, (24'($urandom) & 24'hFFF800) | 24'(lb));
        queue_write(CFG_REFRACTORY, {8'($urandom), rf});
        if ($urandom_range(1) == 0) begin
          queue_write($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, 24'($urandom));
        end
      end
      write_regs();
      if (p == PRESSURE_PHASE) begin
        stall_request = 1'b1;
      end
      if (p == RANDOM_PHASES - 1) begin
        idle_on = 1'b0;
      end
      send_burst_sequence(PHASE_SAMPLES);
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d result beats, %0d of them detections, across %0d register settings,",
             beats_checked, hits_seen, settings_used);
    $display("with random gaps on both channels and one %0d-cycle output stall.", LONG_STALL);
    if (fail_count == 0) begin
      $display("low_band_transient_detector verification clean");
    end else begin
      $display("low_band_transient_detector verification failed");
    end
    $finish;
  end

endmodule
